>>> sv/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and constants for the load average tracker.
// ----------------------------------------------------------------------------
package lat_pkg;

  // Item kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Process state codes
  localparam logic [2:0] PS_UNUSED   = 3'd0;
  localparam logic [2:0] PS_NEW      = 3'd1;
  localparam logic [2:0] PS_RUNNABLE = 3'd2;
  localparam logic [2:0] PS_SLEEPING = 3'd3;
  localparam logic [2:0] PS_STOPPED  = 3'd4;
  localparam logic [2:0] PS_ONPROC   = 3'd5;

  // Register indexes
  localparam int unsigned REG_MAX_SLEEP = 0;

  localparam logic [7:0] DEFAULT_MAX_SLEEP = 8'd20;

  localparam int unsigned COUNT_W   = 13;
  localparam logic [12:0] COUNT_MAX = 13'd8191;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned RES_LIMIT = 8;
  localparam logic [1:0]  GLB_LAST  = 2'd2;

  // e^(-1/12), e^(-1/60), e^(-1/180) with 32 fraction bits, truncated
  localparam logic [31:0] DECAY32_ONE     = 32'd3951560671;
  localparam logic [31:0] DECAY32_FIVE    = 32'd4223977730;
  localparam logic [31:0] DECAY32_FIFTEEN = 32'd4271172524;

  typedef struct packed {
    logic        kind;
    logic [2:0]  proc_state;
    logic        is_idle_thread;
    logic        has_cpu;
    logic [2:0]  cpu_number;
    logic [31:0] uptime_seconds;
    logic [15:0] swapper_sleep_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  cpu_id;
    logic [31:0] cpu_load;
    logic [31:0] load_one;
    logic [31:0] load_five;
    logic [31:0] load_fifteen;
    logic        sampled;
    logic        wake_swapper;
    logic        last;
  } out_item_t;

  // Request to the average update unit
  typedef struct packed {
    logic                  load;
    logic [31:0]           avg;
    logic [COEF_W-1:0]     coef;
    logic [COUNT_W-1:0]    n;
  } upd_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_WR,
    ST_GLB_MUL,
    ST_GLB_ADD,
    ST_CPU_RD,
    ST_CPU_MUL,
    ST_CPU_WR
  } seq_state_e;

endpackage

>>> sv/load_average_tracker.sv
// ----------------------------------------------------------------------------
// load_average_tracker
// Run counts and 1/5/15 minute exponential load averages with per-CPU
// 1-minute averages.
// ----------------------------------------------------------------------------
// Records: a record that counts toward a CPU keeps the input stalled in
//   ST_REC_WR for the count RAM read-modify-write.
// Ticks: global updates (multiply, then add, per average) when sampled, then
//   read, multiply, write per CPU through the one shared update unit and the
//   single read port of the CPU RAMs; a reported CPU's write waits while out is stalled.
// Reset: counts and averages read as zero through valid bits, max_sleep = 20.
// ----------------------------------------------------------------------------
module load_average_tracker
  import lat_pkg::*;
#(
  parameter int MAX_CPUS  = 8,
  parameter int FRAC_BITS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CPU_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int NRES  = (MAX_CPUS < RES_LIMIT) ? MAX_CPUS : RES_LIMIT;
  localparam logic [CPU_W-1:0] LAST_CPU = CPU_W'(MAX_CPUS - 1);
  localparam logic [CPU_W-1:0] LAST_RES = CPU_W'(NRES - 1);

  // Decay coefficients with FRAC_BITS fraction bits
  localparam logic [COEF_W-1:0] COEF_ONE     = COEF_W'(DECAY32_ONE >> (32 - FRAC_BITS));
  localparam logic [COEF_W-1:0] COEF_FIVE    = COEF_W'(DECAY32_FIVE >> (32 - FRAC_BITS));
  localparam logic [COEF_W-1:0] COEF_FIFTEEN = COEF_W'(DECAY32_FIFTEEN >> (32 - FRAC_BITS));

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
    return (x == COUNT_MAX) ? COUNT_MAX : x + COUNT_W'(1);
  endfunction

  // uptime mod 5 == 0: 16 is 1 mod 5, so fold nibbles, then trim.
  function automatic logic mod5_zero(input logic [31:0] up);
    logic [6:0] s;
    logic [4:0] r;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(up[4*i +: 4]);
    end
    r = 5'(s[3:0]) + 5'(s[6:4]);
    for (int j = 0; j < 4; j++) begin
      if (r >= 5'd5) begin
        r = r - 5'd5;
      end
    end
    return r == 5'd0;
  endfunction

  seq_state_e state_q, state_d;

  logic [7:0]         max_sleep_q;
  logic [31:0]        glb_q [3];
  logic [COUNT_W-1:0] run_total_q;
  logic [MAX_CPUS-1:0] cnt_vld_q;
  logic [MAX_CPUS-1:0] avg_vld_q;
  logic [1:0]         g_q;
  logic [CPU_W-1:0]   k_q;
  logic [CPU_W-1:0]   rec_idx_q;
  logic               sampled_q;
  logic               wake_q;
  logic               n_nz_q;
  logic [31:0]        avg_cur_q;
  logic               out_vld_q;
  out_item_t          out_q;

  // Input decode
  logic in_acc;
  logic rec_count;
  logic rec_cpu_ok;
  logic tick_sampled;
  logic tick_wake;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign rec_count    = (in_item_i.proc_state == PS_NEW) ||
                        (((in_item_i.proc_state == PS_RUNNABLE) ||
                          (in_item_i.proc_state == PS_ONPROC)) && !in_item_i.is_idle_thread);
  assign rec_cpu_ok   = in_item_i.has_cpu && (32'(in_item_i.cpu_number) < MAX_CPUS);
  assign tick_sampled = mod5_zero(in_item_i.uptime_seconds);
  assign tick_wake    = in_item_i.swapper_sleep_time > 16'(max_sleep_q >> 1);

  // RAM ports and update unit
  logic [CPU_W-1:0]   cnt_raddr;
  logic               cnt_we;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] cnt_rdata;
  logic               avg_we;
  logic [31:0]        avg_rdata;
  logic [31:0]        upd_sum;
  upd_req_t           upd_req;
  logic [COUNT_W-1:0] cnt_cur;
  logic [31:0]        avg_new;
  logic               emit;
  logic               out_free;
  logic               out_load;
  logic               advance;

  lat_ram #(.Width(COUNT_W), .Depth(MAX_CPUS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (rec_idx_q),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  lat_ram #(.Width(32), .Depth(MAX_CPUS)) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (avg_we),
    .waddr_i (k_q),
    .wdata_i (avg_new),
    .raddr_i (k_q),
    .rdata_o (avg_rdata)
  );

  lat_avg_unit #(.FRAC_BITS(FRAC_BITS)) u_avg_unit (
    .clk_i (clk_i),
    .req_i (upd_req),
    .sum_o (upd_sum)
  );

  // Entries not yet written since reset (or since the last tick for counts)
  // read as zero.
  assign cnt_cur  = (state_q == ST_REC_WR) ? (cnt_vld_q[rec_idx_q] ? cnt_rdata : '0)
                                           : (cnt_vld_q[k_q] ? cnt_rdata : '0);
  assign avg_new  = (sampled_q && n_nz_q) ? upd_sum : avg_cur_q;
  assign emit     = (k_q <= LAST_RES);
  assign out_free = !out_vld_q || !out_stall_i;
  assign advance  = !emit || out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.kind == KIND_TICK) begin
            state_d = tick_sampled ? ST_GLB_MUL : ST_CPU_RD;
          end else if (rec_count && rec_cpu_ok) begin
            state_d = ST_REC_WR;
          end
        end
      end
      ST_REC_WR:  state_d = ST_IDLE;
      ST_GLB_MUL: state_d = ST_GLB_ADD;
      ST_GLB_ADD: state_d = (g_q == GLB_LAST) ? ST_CPU_RD : ST_GLB_MUL;
      ST_CPU_RD:  state_d = ST_CPU_MUL;
      ST_CPU_MUL: state_d = ST_CPU_WR;
      ST_CPU_WR: begin
        if (advance) begin
          state_d = (k_q == LAST_CPU) ? ST_IDLE : ST_CPU_RD;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    cnt_raddr    = k_q;
    cnt_we       = 1'b0;
    cnt_wdata    = sat_inc(cnt_cur);
    avg_we       = 1'b0;
    out_load     = 1'b0;
    upd_req.load = 1'b0;
    upd_req.avg  = avg_vld_q[k_q] ? avg_rdata : '0;
    upd_req.coef = COEF_ONE;
    upd_req.n    = cnt_cur;
    case (state_q)
      ST_IDLE: begin
        // look up the record's CPU count while the item is taken
        cnt_raddr = CPU_W'(in_item_i.cpu_number);
      end
      ST_REC_WR: begin
        cnt_we = 1'b1;
      end
      ST_GLB_MUL: begin
        upd_req.load = 1'b1;
        upd_req.n    = run_total_q;
        case (g_q)
          2'd0:    begin upd_req.avg = glb_q[0]; upd_req.coef = COEF_ONE;     end
          2'd1:    begin upd_req.avg = glb_q[1]; upd_req.coef = COEF_FIVE;    end
          default: begin upd_req.avg = glb_q[2]; upd_req.coef = COEF_FIFTEEN; end
        endcase
      end
      ST_CPU_MUL: begin
        upd_req.load = 1'b1;
      end
      ST_CPU_WR: begin
        avg_we   = sampled_q && n_nz_q && advance;
        out_load = emit && out_free;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_sleep_q <= DEFAULT_MAX_SLEEP;
      glb_q[0]    <= '0;
      glb_q[1]    <= '0;
      glb_q[2]    <= '0;
      run_total_q <= '0;
      cnt_vld_q   <= '0;
      avg_vld_q   <= '0;
      g_q         <= '0;
      k_q         <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (psel && penable && pwrite && (paddr[2] == 1'(REG_MAX_SLEEP))) begin
        max_sleep_q <= pwdata[7:0];
      end

      if (in_acc && (in_item_i.kind == KIND_TICK)) begin
        g_q <= '0;
        k_q <= '0;
      end else if (in_acc && rec_count) begin
        run_total_q <= sat_inc(run_total_q);
      end

      if (state_q == ST_REC_WR) begin
        cnt_vld_q[rec_idx_q] <= 1'b1;
      end

      if (state_q == ST_GLB_ADD) begin
        glb_q[g_q] <= upd_sum;
        g_q        <= g_q + 2'd1;
      end

      if ((state_q == ST_CPU_WR) && advance) begin
        if (avg_we) begin
          avg_vld_q[k_q] <= 1'b1;
        end
        if (k_q == LAST_CPU) begin
          // tick done: drop all counts
          run_total_q <= '0;
          cnt_vld_q   <= '0;
        end else begin
          k_q <= k_q + CPU_W'(1);
        end
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rec_idx_q <= CPU_W'(in_item_i.cpu_number);
      if (in_item_i.kind == KIND_TICK) begin
        sampled_q <= tick_sampled;
        wake_q    <= tick_wake;
      end
    end
    if (state_q == ST_CPU_MUL) begin
      n_nz_q    <= (cnt_cur != '0);
      avg_cur_q <= upd_req.avg;
    end
    if (out_load) begin
      out_q.cpu_id       <= 3'(k_q);
      out_q.cpu_load     <= avg_new;
      out_q.load_one     <= glb_q[0];
      out_q.load_five    <= glb_q[1];
      out_q.load_fifteen <= glb_q[2];
      out_q.sampled      <= sampled_q;
      out_q.wake_swapper <= wake_q;
      out_q.last         <= (k_q == LAST_RES);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(REG_MAX_SLEEP)) ? {24'd0, max_sleep_q} : 32'd0;

endmodule

>>> sv/lat_ram.sv
// ----------------------------------------------------------------------------
// lat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lat_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lat_avg_unit.sv
// ----------------------------------------------------------------------------
// lat_avg_unit
// Exponential average step: (c*avg) >> F plus n*(2^F - c), saturated.
// ----------------------------------------------------------------------------
module lat_avg_unit
  import lat_pkg::*;
#(
  parameter int FRAC_BITS = 11
) (
  input  logic        clk_i,
  input  upd_req_t    req_i,
  output logic [31:0] sum_o
);

  localparam int PA_W  = 32 + COEF_W;
  localparam int PB_W  = COUNT_W + COEF_W + 1;
  localparam int SUM_W = ((32 > PB_W) ? 32 : PB_W) + 1;
  localparam logic [COEF_W:0] FSCALE = (COEF_W + 1)'(1) << FRAC_BITS;

  logic [PA_W-1:0]  prod_a_q;
  logic [PB_W-1:0]  prod_b_q;
  logic [COEF_W:0]  comp;
  logic [SUM_W-1:0] sum;

  assign comp = FSCALE - {1'b0, req_i.coef};

  // Register both products before the add.
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prod_a_q <= PA_W'(req_i.coef) * PA_W'(req_i.avg);
      prod_b_q <= PB_W'(req_i.n) * PB_W'(comp);
    end
  end

  assign sum   = SUM_W'(prod_a_q >> FRAC_BITS) + SUM_W'(prod_b_q);
  assign sum_o = (|sum[SUM_W-1:32]) ? 32'hFFFF_FFFF : sum[31:0];

endmodule

>>> sv/lat_checker.sv
// ----------------------------------------------------------------------------
// lat_checker
// Port-level checks of the load average tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lat_checker
  import lat_pkg::*;
#(
  parameter int MAX_CPUS = 8
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  localparam int NRES = (MAX_CPUS < RES_LIMIT) ? MAX_CPUS : RES_LIMIT;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // a tick keeps the input stalled while it walks the CPUs
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.kind == KIND_TICK) |=> in_stall_o)
    else $error("input taken during tick processing");

  // the final result of a tick belongs to the highest reported CPU
  a_last_cpu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |-> (32'(out_item_o.cpu_id) == NRES - 1))
    else $error("last flag on wrong CPU");

  // a process record never produces a result
  a_rec_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.kind == KIND_RECORD) && !out_valid_o
    |=> !out_valid_o)
    else $error("result produced by a process record");

endmodule

bind load_average_tracker lat_checker #(.MAX_CPUS(MAX_CPUS)) u_lat_checker (.*);

>>> sim/load_average_tracker_tb.sv
// ----------------------------------------------------------------------------
// load_average_tracker_tb
// Self-checking bench: drives process records and meter ticks through the
// valid/stall input, predicts the per-CPU tick results from its own model of
// the run counts and fixed-point decay, and compares every result field by
// field. Configures max_sleep over the APB-style port between phases.
// ----------------------------------------------------------------------------
module load_average_tracker_tb;
  import lat_pkg::*;

  localparam int CPUS          = 8;
  localparam int FRAC_BITS     = 11;
  localparam int NUM_RESULTS   = (CPUS < RES_LIMIT) ? CPUS : RES_LIMIT;
  localparam int SAMPLE_PERIOD = 5;
  // slowest tick: global pass plus read/multiply/write per CPU, with margin
  localparam int SETTLE_CYCLES = 3 * CPUS + 16;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int WALK_ITEMS    = 60;
  localparam int PILE_ITEMS    = 24;

  // decay factors at FRAC_BITS fraction bits
  localparam logic [63:0] COEF_ONE     = {32'd0, DECAY32_ONE} >> (32 - FRAC_BITS);
  localparam logic [63:0] COEF_FIVE    = {32'd0, DECAY32_FIVE} >> (32 - FRAC_BITS);
  localparam logic [63:0] COEF_FIFTEEN = {32'd0, DECAY32_FIFTEEN} >> (32 - FRAC_BITS);

  typedef enum logic [1:0] {FLOW_FREE, FLOW_RANDOM, FLOW_RUNS} flow_e;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  out_item_t   out_item_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted block state, held in step with accepted items
  logic [7:0]  sleep_limit = DEFAULT_MAX_SLEEP;
  logic [31:0] avg_one     = '0;
  logic [31:0] avg_five    = '0;
  logic [31:0] avg_fifteen = '0;
  logic [31:0] core_avg   [CPUS];
  logic [12:0] run_count   = '0;
  logic [12:0] core_count [CPUS];

  in_item_t    items_to_send [$];
  out_item_t   load_results_due [$];
  logic [31:0] uptime_now  = '0;
  int          mismatches  = 0;
  int          cycle_count = 0;

  // Sender burst shaping and receiver stall pattern
  int          burst_left = 1;
  int          gap_left   = 0;
  flow_e       stall_mode = FLOW_FREE;
  int          mode_left  = 0;
  int          stall_run  = 0;

  initial begin
    for (int i = 0; i < CPUS; i++) begin
      core_avg[i]   = '0;
      core_count[i] = '0;
    end
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  load_average_tracker #(
    .MAX_CPUS  (CPUS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // One exponential step, computed wide and clamped to 32 bits.
  function automatic logic [31:0] decay_avg(input logic [31:0] avg,
                                            input logic [63:0] coef,
                                            input logic [12:0] n);
    logic [63:0] fs;
    logic [63:0] v;
    fs = 64'd1 << FRAC_BITS;
    v  = (coef * {32'd0, avg} + {51'd0, n} * fs * (fs - coef)) >> FRAC_BITS;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Fold one accepted item into the predicted state; a tick queues its results.
  task automatic track_item(input in_item_t it);
    logic      counts;
    logic      sampled;
    logic      wake;
    out_item_t r;
    if (it.kind == KIND_RECORD) begin
      // new always counts; runnable and on-processor unless the idle thread
      counts = (it.proc_state == PS_NEW) ||
               ((it.proc_state == PS_RUNNABLE || it.proc_state == PS_ONPROC) &&
                !it.is_idle_thread);
      if (counts) begin
        if (run_count != COUNT_MAX) run_count = run_count + 13'd1;
        if (it.has_cpu && int'(it.cpu_number) < CPUS &&
            core_count[it.cpu_number] != COUNT_MAX) begin
          core_count[it.cpu_number] = core_count[it.cpu_number] + 13'd1;
        end
      end
    end else begin
      sampled = (it.uptime_seconds % SAMPLE_PERIOD) == 0;
      if (sampled) begin
        avg_one     = decay_avg(avg_one, COEF_ONE, run_count);
        avg_five    = decay_avg(avg_five, COEF_FIVE, run_count);
        avg_fifteen = decay_avg(avg_fifteen, COEF_FIFTEEN, run_count);
        for (int i = 0; i < CPUS; i++) begin
          if (core_count[i] != '0) core_avg[i] = decay_avg(core_avg[i], COEF_ONE, core_count[i]);
        end
      end
      wake = it.swapper_sleep_time > {8'd0, sleep_limit >> 1};
      run_count = '0;
      for (int i = 0; i < CPUS; i++) core_count[i] = '0;
      for (int k = 0; k < NUM_RESULTS; k++) begin
        r.cpu_id       = 3'(k);
        r.cpu_load     = core_avg[k];
        r.load_one     = avg_one;
        r.load_five    = avg_five;
        r.load_fifteen = avg_fifteen;
        r.sampled      = sampled;
        r.wake_swapper = wake;
        r.last         = (k == NUM_RESULTS - 1);
        load_results_due.push_back(r);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (load_results_due.size() == 0) begin
      report("result with nothing due, cpu_id", 32'(got.cpu_id), '0);
    end else begin
      want = load_results_due.pop_front();
      if (got.cpu_id !== want.cpu_id) report("cpu_id", 32'(got.cpu_id), 32'(want.cpu_id));
      if (got.cpu_load !== want.cpu_load) report("cpu_load", got.cpu_load, want.cpu_load);
      if (got.load_one !== want.load_one) report("load_one", got.load_one, want.load_one);
      if (got.load_five !== want.load_five) report("load_five", got.load_five, want.load_five);
      if (got.load_fifteen !== want.load_fifteen) begin
        report("load_fifteen", got.load_fifteen, want.load_fifteen);
      end
      if (got.sampled !== want.sampled) report("sampled", 32'(got.sampled), 32'(want.sampled));
      if (got.wake_swapper !== want.wake_swapper) begin
        report("wake_swapper", 32'(got.wake_swapper), 32'(want.wake_swapper));
      end
      if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued items in bursts, hold the payload while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || !in_stall_o) begin
      // the item on the bus (if any) was taken at this edge
      if (in_valid) track_item(in_item);
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_item  <= items_to_send.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // half the bursts run back to back with no gap
          gap_left   <= ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check taken results, stall on a pattern that changes mode
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) check_result(out_item_o);
      if (mode_left == 0) begin
        stall_mode <= flow_e'($urandom_range(0, 2));
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left  <= mode_left - 1;
      end
      case (stall_mode)
        FLOW_FREE: begin
          out_stall <= 1'b0;
        end
        FLOW_RANDOM: begin
          out_stall <= 1'($urandom_range(0, 1));
        end
        default: begin
          // long stretches of stall separated by open cycles
          if (stall_run != 0) begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
            stall_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
          end
        end
      endcase
    end
  end

  // Watchdog: give up well beyond the slowest correct run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Record with the given process fields; tick-only fields carry junk.
  function automatic in_item_t make_record(input logic [2:0] st, input logic idle,
                                           input logic has_cpu, input logic [2:0] cpu);
    in_item_t it;
    it.kind               = KIND_RECORD;
    it.proc_state         = st;
    it.is_idle_thread     = idle;
    it.has_cpu            = has_cpu;
    it.cpu_number         = cpu;
    it.uptime_seconds     = $urandom;
    it.swapper_sleep_time = 16'($urandom);
    return it;
  endfunction

  // Tick with the given uptime and sleep; record-only fields carry junk.
  function automatic in_item_t make_tick(input logic [31:0] up, input logic [15:0] slp);
    in_item_t it;
    it.kind               = KIND_TICK;
    it.proc_state         = 3'($urandom_range(0, 7));
    it.is_idle_thread     = 1'($urandom_range(0, 1));
    it.has_cpu            = 1'($urandom_range(0, 1));
    it.cpu_number         = 3'($urandom_range(0, 7));
    it.uptime_seconds     = up;
    it.swapper_sleep_time = slp;
    return it;
  endfunction

  // Sleep times clustered on the wake threshold of the current setting.
  function automatic logic [15:0] pick_sleep();
    logic [15:0] half;
    half = {8'd0, sleep_limit >> 1};
    case ($urandom_range(0, 3))
      0:       return half;
      1:       return half + 16'd1;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Walk record: mostly counting states, mostly with a CPU.
  function automatic in_item_t walk_record();
    logic [2:0] st;
    case ($urandom_range(0, 4))
      0:       st = PS_NEW;
      1:       st = PS_RUNNABLE;
      2:       st = PS_ONPROC;
      default: st = 3'($urandom_range(0, 7));
    endcase
    return make_record(st, ($urandom_range(0, 4) == 0), ($urandom_range(0, 4) != 0),
                       3'($urandom_range(0, 7)));
  endfunction

  // Uptime mostly steps by one second, now and then jumps anywhere.
  function automatic in_item_t next_tick();
    if ($urandom_range(0, 9) == 0) uptime_now = $urandom;
    else uptime_now = uptime_now + 32'd1;
    return make_tick(uptime_now, pick_sleep());
  endfunction

  // Queue sample walks (records then a tick), with some noise items mixed in.
  task automatic send_walks(input int count);
    int pushed;
    int len;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          items_to_send.push_back(make_tick($urandom, 16'($urandom)));
        end else begin
          items_to_send.push_back(make_record(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
        end
        pushed++;
      end else begin
        len = $urandom_range(0, 12);
        for (int k = 0; k < len; k++) items_to_send.push_back(walk_record());
        items_to_send.push_back(next_tick());
        pushed += len + 1;
      end
    end
  endtask

  // Hold until every item is taken and every result has come, then let
  // any record still in flight finish.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid || load_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_max_sleep();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(4 * REG_MAX_SLEEP);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== sleep_limit) report("max_sleep readback", prdata, 32'(sleep_limit));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_max_sleep(input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_MAX_SLEEP);
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // written at this edge
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    sleep_limit  = value;
    check_max_sleep();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_max_sleep();

    // Directed: counting rules, ignored states, sampling and wake edges.
    items_to_send.push_back(make_record(PS_NEW, 1'b1, 1'b1, 3'd0));      // new counts even idle
    items_to_send.push_back(make_record(PS_RUNNABLE, 1'b0, 1'b1, 3'd7));
    items_to_send.push_back(make_record(PS_RUNNABLE, 1'b1, 1'b1, 3'd7)); // idle thread: drop
    items_to_send.push_back(make_record(PS_ONPROC, 1'b0, 1'b0, 3'd5));   // global count only
    items_to_send.push_back(make_record(PS_ONPROC, 1'b0, 1'b1, 3'd5));
    items_to_send.push_back(make_record(PS_ONPROC, 1'b1, 1'b1, 3'd2));
    items_to_send.push_back(make_record(PS_UNUSED, 1'b0, 1'b1, 3'd1));
    items_to_send.push_back(make_record(PS_SLEEPING, 1'b0, 1'b1, 3'd1));
    items_to_send.push_back(make_record(PS_STOPPED, 1'b0, 1'b1, 3'd1));
    items_to_send.push_back(make_record(3'd6, 1'b0, 1'b1, 3'd4));        // undefined codes
    items_to_send.push_back(make_record(3'd7, 1'b0, 1'b1, 3'd4));
    items_to_send.push_back(make_tick(32'd0, 16'd0));                    // sampled, no wake
    items_to_send.push_back(make_record(PS_NEW, 1'b0, 1'b1, 3'd3));
    items_to_send.push_back(make_tick(32'd1, 16'd10));                   // not sampled, at half
    items_to_send.push_back(make_record(PS_NEW, 1'b0, 1'b1, 3'd3));
    items_to_send.push_back(make_record(PS_NEW, 1'b0, 1'b1, 3'd3));
    items_to_send.push_back(make_tick(32'd5, 16'd11));                   // just above half
    items_to_send.push_back(make_record(PS_RUNNABLE, 1'b0, 1'b1, 3'd0));
    items_to_send.push_back(make_tick(32'hFFFF_FFFF, 16'hFFFF));         // top uptime, sampled
    items_to_send.push_back(make_tick(32'hFFFF_FFFE, 16'hFFFF));         // nothing counted
    items_to_send.push_back(make_tick(32'd10, 16'd0));                   // decay with no load
    wait_idle();

    // Random walks across several wake thresholds, extremes included.
    set_max_sleep(8'd0);
    send_walks(WALK_ITEMS);
    wait_idle();

    set_max_sleep(8'd255);
    send_walks(WALK_ITEMS);
    wait_idle();

    // Pile counts onto one CPU, then sample twice.
    for (int k = 0; k < PILE_ITEMS; k++) begin
      items_to_send.push_back(make_record(PS_NEW, 1'($urandom_range(0, 1)), 1'b1, 3'd6));
    end
    items_to_send.push_back(make_tick(32'd20, pick_sleep()));
    items_to_send.push_back(make_tick(32'd25, pick_sleep()));
    wait_idle();

    set_max_sleep(8'($urandom_range(1, 254)));
    send_walks(WALK_ITEMS);
    wait_idle();

    set_max_sleep(DEFAULT_MAX_SLEEP);
    send_walks(WALK_ITEMS);
    wait_idle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lat_pkg.sv
sv/lat_ram.sv
sv/lat_avg_unit.sv
sv/load_average_tracker.sv
sv/lat_checker.sv
sim/load_average_tracker_tb.sv
